@@ hw/rtl/lpa_pkg.sv @@
// Shared types and constants for the looping phase accumulator.
package lpa_pkg;

    localparam int POS_W    = 48;   // Q32.16 position
    localparam int LEVEL_W  = 50;   // signed Q34.16 running level
    localparam int TRIG_W   = 16;   // Q1.15 trigger samples
    localparam int RATE_W   = 32;   // signed Q16.16 rate
    localparam int FRAC_W   = 16;   // Q0.16 restart fraction
    localparam int PROD_W   = FRAC_W + 1 + RATE_W;
    localparam int DIV_STEPS = LEVEL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_POSITION = 2'd0,
        REG_END_POSITION   = 2'd1,
        REG_LOOP_START     = 2'd2,
        REG_LOOP_END       = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAC_DIV,
        ST_FRAC_MUL,
        ST_RESTART,
        ST_WRAP_SEL,
        ST_WRAP_DIV,
        ST_WRAP_FIX,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] dividend;
        logic [POS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
        logic [POS_W-1:0]   remainder;
    } div_rsp_t;

endpackage

@@ hw/rtl/loop_phase_accumulator_top.sv @@
// Top level of the looping sample-playback phase accumulator.
//
// Usage notes:
//  - Input channel s_*: one audio sample per transaction (restart trigger,
//    finish trigger, signed Q16.16 rate). Result channel m_*: one
//    transaction per input, carrying the Q32.16 position and finish flag.
//  - Config port: cfg_wr_en/cfg_index/cfg_wdata writes start, end, loop
//    start and loop end (Q32.16). Write only while the block is idle.
//  - One transaction at a time: s_ready is high only in the idle state.
//  - A plain sample, a finish clamp or an empty region skips the divider;
//    a position wrap takes one pass of the divider, a restart without a
//    wrap one pass, and a restart plus a wrap two passes. s_ready rises
//    with m_valid, so a new sample is taken only once the previous result
//    has reached the output register. The shared 50-step restoring divider
//    computes the restart fraction and the modulo wrap, one bit per cycle.
//  - A finished result sits in an output register; if the receiver
//    stalls (m_ready low) the next sample is still accepted, and its
//    result waits in the final state until the output register frees.
//  - Reset (aresetn low, synchronous) clears the config registers,
//    the level, both trigger histories and finish mode, and drops m_valid.
module loop_phase_accumulator_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [lpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lpa_pkg::POS_W-1:0]            cfg_wdata,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [lpa_pkg::TRIG_W-1:0]    s_start_trigger,
    input  logic signed [lpa_pkg::TRIG_W-1:0]    s_finish_trigger,
    input  logic signed [lpa_pkg::RATE_W-1:0]    s_rate_step,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lpa_pkg::POS_W-1:0]            m_position,
    output logic                                 m_finishing
);

    localparam int LW = lpa_pkg::LEVEL_W;
    localparam int PW = lpa_pkg::POS_W;
    localparam int TW = lpa_pkg::TRIG_W;
    localparam int FW = lpa_pkg::FRAC_W;
    localparam int XW = lpa_pkg::PROD_W;

    // configuration registers
    logic [PW-1:0] start_pos_reg;
    logic [PW-1:0] end_pos_reg;
    logic [PW-1:0] loop_start_reg;
    logic [PW-1:0] loop_end_reg;

    // sequencer and state
    lpa_pkg::seq_state_t state_reg, state_next;
    logic signed [LW-1:0]             level_reg;
    logic signed [TW-1:0]             prev_st_reg;
    logic signed [TW-1:0]             prev_ft_reg;
    logic                             finish_mode_reg;
    logic signed [lpa_pkg::RATE_W-1:0] rate_reg;
    logic [FW-1:0]                    frac_reg;
    logic signed [XW-1:0]             prod_reg;
    logic [PW-1:0]                    lo_reg;
    logic [PW-1:0]                    wrap_m_reg;
    logic                             neg_reg;
    logic [PW-1:0]                    range_reg;

    // output register
    logic                             out_valid_reg;
    logic [PW-1:0]                    out_pos_reg;
    logic                             out_fin_reg;

    lpa_pkg::div_req_t div_req;
    lpa_pkg::div_rsp_t div_rsp;

    // accept and trigger edges
    logic                accept;
    logic                st_rise;
    logic                ft_rise;
    logic signed [TW:0]  st_den;

    assign accept  = s_valid && s_ready;
    assign st_rise = (prev_st_reg <= 0) && (s_start_trigger > 0);
    assign ft_rise = (prev_ft_reg <= 0) && (s_finish_trigger > 0);
    assign st_den  = {s_start_trigger[TW-1], s_start_trigger}
                   - {prev_st_reg[TW-1], prev_st_reg};

    // zero-extended config values in level format
    logic signed [LW-1:0] s_ext, e_ext, ls_ext, le_ext;
    assign s_ext  = signed'({2'b00, start_pos_reg});
    assign e_ext  = signed'({2'b00, end_pos_reg});
    assign ls_ext = signed'({2'b00, loop_start_reg});
    assign le_ext = signed'({2'b00, loop_end_reg});

    // region selection for the wrap
    logic                 in_loop;
    logic [PW-1:0]        sel_lo;
    logic [PW-1:0]        sel_hi;
    logic signed [PW:0]   sel_range;
    logic                 range_empty;
    logic signed [LW-1:0] wrap_diff;
    logic [LW-1:0]        wrap_mag;

    assign in_loop     = (level_reg >= ls_ext) && (level_reg <= le_ext);
    assign sel_lo      = in_loop ? loop_start_reg : start_pos_reg;
    assign sel_hi      = in_loop ? loop_end_reg   : end_pos_reg;
    assign sel_range   = signed'({1'b0, sel_hi}) - signed'({1'b0, sel_lo});
    assign range_empty = sel_range[PW] || (sel_range == '0);
    assign wrap_diff   = level_reg - signed'({2'b00, sel_lo});
    assign wrap_mag    = wrap_diff[LW-1] ? LW'(-wrap_diff) : LW'(wrap_diff);

    // finish clamp: max with start, then min with end
    logic signed [LW-1:0] clamp_lo;
    logic signed [LW-1:0] clamp_val;
    assign clamp_lo  = (level_reg < s_ext) ? s_ext : level_reg;
    assign clamp_val = (clamp_lo > e_ext) ? e_ext : clamp_lo;

    // restart offset: floor(frac * rate / 2^16)
    logic signed [XW-17:0] restart_step;
    assign restart_step = prod_reg[XW-1:16];

    logic out_free;
    assign out_free = !out_valid_reg || m_ready;

    lpa_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lpa_pkg::ST_IDLE:     if (accept) begin
                                      state_next = st_rise ? lpa_pkg::ST_FRAC_DIV
                                                           : lpa_pkg::ST_WRAP_SEL;
                                  end
            lpa_pkg::ST_FRAC_DIV: if (div_rsp.done) begin
                                      state_next = lpa_pkg::ST_FRAC_MUL;
                                  end
            lpa_pkg::ST_FRAC_MUL: state_next = lpa_pkg::ST_RESTART;
            lpa_pkg::ST_RESTART:  state_next = lpa_pkg::ST_WRAP_SEL;
            lpa_pkg::ST_WRAP_SEL: begin
                if (finish_mode_reg || range_empty) begin
                    state_next = lpa_pkg::ST_DONE;
                end else begin
                    state_next = lpa_pkg::ST_WRAP_DIV;
                end
            end
            lpa_pkg::ST_WRAP_DIV: if (div_rsp.done) begin
                                      state_next = lpa_pkg::ST_WRAP_FIX;
                                  end
            lpa_pkg::ST_WRAP_FIX: state_next = lpa_pkg::ST_DONE;
            lpa_pkg::ST_DONE:     if (out_free) begin
                                      state_next = lpa_pkg::ST_IDLE;
                                  end
            default:              state_next = lpa_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and divider launch
    always_comb begin
        s_ready          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            lpa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                // frac = st * 2^16 / (st - prev), st known positive here
                div_req.start    = s_valid && st_rise;
                div_req.dividend = {{(LW-FW-TW+1){1'b0}}, s_start_trigger[TW-2:0],
                                    {FW{1'b0}}};
                div_req.divisor  = {{(PW-TW-1){1'b0}}, st_den};
            end
            lpa_pkg::ST_WRAP_SEL: begin
                div_req.start    = !finish_mode_reg && !range_empty;
                div_req.dividend = wrap_mag;
                div_req.divisor  = sel_range[PW-1:0];
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pos_reg  <= '0;
            end_pos_reg    <= '0;
            loop_start_reg <= '0;
            loop_end_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (lpa_pkg::cfg_reg_t'(cfg_index))
                lpa_pkg::REG_START_POSITION: start_pos_reg  <= cfg_wdata;
                lpa_pkg::REG_END_POSITION:   end_pos_reg    <= cfg_wdata;
                lpa_pkg::REG_LOOP_START:     loop_start_reg <= cfg_wdata;
                lpa_pkg::REG_LOOP_END:       loop_end_reg   <= cfg_wdata;
                default:                     ;
            endcase
        end
    end

    // control state: level, trigger history, finish mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg       <= '0;
            prev_st_reg     <= '0;
            prev_ft_reg     <= '0;
            finish_mode_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                lpa_pkg::ST_IDLE: if (accept) begin
                    prev_st_reg     <= s_start_trigger;
                    prev_ft_reg     <= s_finish_trigger;
                    finish_mode_reg <= finish_mode_reg ^ ft_rise;
                end
                lpa_pkg::ST_RESTART: begin
                    level_reg <= s_ext + signed'({{(LW-XW+16){restart_step[XW-17]}},
                                                  restart_step});
                end
                lpa_pkg::ST_WRAP_SEL: begin
                    if (finish_mode_reg) begin
                        level_reg <= clamp_val;
                    end else if (range_empty) begin
                        level_reg <= signed'({2'b00, sel_lo});
                    end
                end
                lpa_pkg::ST_WRAP_FIX: begin
                    level_reg <= signed'({2'b00, lo_reg}) + signed'({2'b00, wrap_m_reg});
                end
                lpa_pkg::ST_DONE: if (out_free) begin
                    level_reg <= level_reg + LW'(rate_reg);
                end
                default: ;
            endcase
        end
    end

    // datapath working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            lpa_pkg::ST_IDLE: if (accept) begin
                rate_reg <= s_rate_step;
            end
            lpa_pkg::ST_FRAC_DIV: if (div_rsp.done) begin
                // a previous sample of exactly zero gives a full-scale fraction
                frac_reg <= (div_rsp.quotient[LW-1:FW] != '0) ? {FW{1'b1}}
                                                             : div_rsp.quotient[FW-1:0];
            end
            lpa_pkg::ST_FRAC_MUL: begin
                prod_reg <= signed'({1'b0, frac_reg}) * rate_reg;
            end
            lpa_pkg::ST_WRAP_SEL: begin
                lo_reg    <= sel_lo;
                range_reg <= sel_range[PW-1:0];
                neg_reg   <= wrap_diff[LW-1];
            end
            lpa_pkg::ST_WRAP_DIV: if (div_rsp.done) begin
                // floor modulo: fold a negative remainder back into range
                wrap_m_reg <= (neg_reg && (div_rsp.remainder != '0))
                            ? range_reg - div_rsp.remainder
                            : div_rsp.remainder;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == lpa_pkg::ST_DONE) && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == lpa_pkg::ST_DONE) && out_free) begin
            out_pos_reg <= level_reg[PW-1:0];
            out_fin_reg <= finish_mode_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_position  = out_pos_reg;
    assign m_finishing = out_fin_reg;

endmodule

@@ hw/rtl/lpa_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
module lpa_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  lpa_pkg::div_req_t req,
    output lpa_pkg::div_rsp_t rsp
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [lpa_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [lpa_pkg::LEVEL_W-1:0]     quo_reg;
    logic [lpa_pkg::POS_W-1:0]       rem_reg;
    logic [lpa_pkg::POS_W-1:0]       dvs_reg;
    logic [lpa_pkg::POS_W:0]         shifted;
    logic [lpa_pkg::POS_W:0]         trial;
    logic                            borrow;

    assign shifted = {rem_reg, quo_reg[lpa_pkg::LEVEL_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign borrow  = shifted < {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lpa_pkg::DIV_CNT_W'(lpa_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so 48 bits hold it
            rem_reg <= borrow ? shifted[lpa_pkg::POS_W-1:0] : trial[lpa_pkg::POS_W-1:0];
            quo_reg <= {quo_reg[lpa_pkg::LEVEL_W-2:0], ~borrow};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ tb/loop_phase_accumulator_checker.sv @@
// Scoreboard for the looping phase accumulator: predicts each position and checks the result.
module loop_phase_accumulator_checker
    import lpa_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [POS_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic signed [TRIG_W-1:0] s_start_trigger,
    input  logic signed [TRIG_W-1:0] s_finish_trigger,
    input  logic signed [RATE_W-1:0] s_rate_step,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [POS_W-1:0]         m_position,
    input  logic                     m_finishing,
    output int                       error_count,
    output int                       outstanding,
    output int                       checked_count,
    output int                       restart_count,
    output int                       toggle_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FRAC_ONE = longint'(1) << FRAC_W;
    localparam longint FRAC_MAX = FRAC_ONE - 1;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             finishing;
    } position_result_t;

    position_result_t expected_positions[$];

    // shadow of the region registers and the accumulator state
    logic [POS_W-1:0]         start_pos;
    logic [POS_W-1:0]         end_pos;
    logic [POS_W-1:0]         loop_lo;
    logic [POS_W-1:0]         loop_hi;
    longint                   level;
    logic signed [TRIG_W-1:0] prev_start;
    logic signed [TRIG_W-1:0] prev_finish;
    logic                     finish_mode;

    // floor-mod wrap into [lo, hi); an empty region collapses to lo
    function automatic longint wrap_region(longint x, longint lo, longint hi);
        longint span;
        longint m;
        span = hi - lo;
        if (span <= 0)
            return lo;
        m = (x - lo) % span;
        if (m < 0)
            m += span;
        return lo + m;
    endfunction

    function automatic position_result_t next_position(logic signed [TRIG_W-1:0] st,
                                                       logic signed [TRIG_W-1:0] ft,
                                                       logic signed [RATE_W-1:0] rate);
        longint           s;
        longint           e;
        longint           ls;
        longint           le;
        longint           rate_l;
        longint           frac;
        position_result_t res;
        s      = longint'(start_pos);
        e      = longint'(end_pos);
        ls     = longint'(loop_lo);
        le     = longint'(loop_hi);
        rate_l = longint'(rate);

        if (prev_start <= 0 && st > 0) begin
            frac = (longint'(st) * FRAC_ONE) / (longint'(st) - longint'(prev_start));
            if (frac > FRAC_MAX)
                frac = FRAC_MAX;
            level = s + ((frac * rate_l) >>> FRAC_W);
            restart_count++;
        end

        if (prev_finish <= 0 && ft > 0) begin
            finish_mode = !finish_mode;
            toggle_count++;
        end

        if (!finish_mode) begin
            if (level >= ls && level <= le)
                level = wrap_region(level, ls, le);
            else
                level = wrap_region(level, s, e);
        end else begin
            if (level < s)
                level = s;
            if (level > e)
                level = e;
        end

        res.position  = level[POS_W-1:0];
        res.finishing = finish_mode;

        level       = level + rate_l;
        prev_start  = st;
        prev_finish = ft;
        return res;
    endfunction

    always @(posedge aclk) begin
        position_result_t want;
        if (!aresetn) begin
            start_pos     = '0;
            end_pos       = '0;
            loop_lo       = '0;
            loop_hi       = '0;
            level         = 0;
            prev_start    = '0;
            prev_finish   = '0;
            finish_mode   = 1'b0;
            error_count   = 0;
            checked_count = 0;
            restart_count = 0;
            toggle_count  = 0;
            expected_positions.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_POSITION: start_pos = cfg_wdata;
                    REG_END_POSITION:   end_pos   = cfg_wdata;
                    REG_LOOP_START:     loop_lo   = cfg_wdata;
                    REG_LOOP_END:       loop_hi   = cfg_wdata;
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (expected_positions.size() == 0) begin
                    $error("unexpected result: position %h finishing %b",
                           m_position, m_finishing);
                    error_count++;
                end else begin
                    want = expected_positions.pop_front();
                    checked_count++;
                    if (m_position !== want.position) begin
                        $error("position: expected %h, actual %h", want.position, m_position);
                        error_count++;
                    end
                    if (m_finishing !== want.finishing) begin
                        $error("finishing: expected %b, actual %b",
                               want.finishing, m_finishing);
                        error_count++;
                    end
                end
            end

            if (s_valid && s_ready)
                expected_positions.push_back(next_position(s_start_trigger, s_finish_trigger,
                                                           s_rate_step));
        end
        outstanding = expected_positions.size();
    end

endmodule

@@ tb/loop_phase_accumulator_top_tb.sv @@
// Stimulus and verdict for the looping phase accumulator testbench.
module loop_phase_accumulator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpa_pkg::*;

    localparam int CLK_HALF       = 6;        // 12 ns clock
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_ITEMS    = 150;      // 11 x 150 random samples
    localparam int SETTLE_CYCLES  = 4;        // idle gap before touching the registers
    localparam int TAIL_CYCLES    = 120;      // tail wait, longer than the slowest sample
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int IDLE_PERCENT   = 15;
    localparam int DIRECTED_COUNT = 20;

    localparam logic [POS_W-1:0]         POS_TOP  = '1;
    localparam logic signed [RATE_W-1:0] RATE_MAX = 32'h7FFF_FFFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN = 32'h8000_0000;

    // Directed samples, packed as {start_trigger, finish_trigger, rate_step}.
    // Regions for this part: start 1, end 1000, loop 100..1000 frames, so the
    // loop end coincides with the playback end and a clamped position lands
    // exactly on the loop boundary.
    localparam logic [63:0] DIRECTED_SAMPLES [DIRECTED_COUNT] = '{
        {16'h0000, 16'h0000, 32'h0001_0000},  // plain step from reset, wraps below start
        {16'h7FFF, 16'h0000, 32'h0004_0000},  // restart from exactly zero: saturated fraction
        {16'h8000, 16'h0000, 32'h0000_8000},  // most negative trigger
        {16'h0001, 16'h0000, 32'h7FFF_FFFF},  // restart from -1.0: tiny fraction, max rate
        {16'hFFFF, 16'h0000, 32'h8000_0000},  // min rate
        {16'h4000, 16'h0000, 32'h8000_0000},  // restart, lands below start: negative modulo
        {16'h0000, 16'h7FFF, 32'h0100_0000},  // finish on
        {16'h0000, 16'h7FFF, 32'h0100_0000},  // held high: no toggle
        {16'h0000, 16'h8000, 32'h7FFF_FFFF},  // clamp above the end
        {16'h0000, 16'hFFFF, 32'h0000_0000},  // clamp, level parks on the end
        {16'h0000, 16'h0001, 32'h0000_0000},  // finish off: level equals loop end
        {16'h0000, 16'h0000, 32'h8000_0000},
        {16'h0000, 16'h4000, 32'h8000_0000},  // finish on again
        {16'h0000, 16'h0000, 32'h8000_0000},  // clamp to the start
        {16'hC000, 16'h0000, 32'h0000_0000},
        {16'h7FFF, 16'h8000, 32'hFFFF_FFFF},  // restart while finishing
        {16'h0000, 16'h7FFF, 32'h0000_0001},  // finish off, smallest step
        {16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF},  // restart, finish held
        {16'h8000, 16'h8000, 32'h8000_0000},
        {16'h7FFF, 16'h7FFF, 32'h0000_0000}   // restart and finish toggle together
    };

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [POS_W-1:0]         cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [TRIG_W-1:0] s_start_trigger;
    logic signed [TRIG_W-1:0] s_finish_trigger;
    logic signed [RATE_W-1:0] s_rate_step;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [POS_W-1:0]         m_position;
    logic                     m_finishing;

    // Scoreboard status
    int error_count;
    int outstanding;
    int checked_count;
    int restart_count;
    int toggle_count;

    // Run bookkeeping
    int   cycle_count  = 0;
    int   sent_count   = 0;
    int   config_count = 0;
    logic quiet        = 1'b0;   // high: neither side idles

    loop_phase_accumulator_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_trigger  (s_start_trigger),
        .s_finish_trigger (s_finish_trigger),
        .s_rate_step      (s_rate_step),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position       (m_position),
        .m_finishing      (m_finishing)
    );

    loop_phase_accumulator_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_trigger  (s_start_trigger),
        .s_finish_trigger (s_finish_trigger),
        .s_rate_step      (s_rate_step),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position       (m_position),
        .m_finishing      (m_finishing),
        .error_count      (error_count),
        .outstanding      (outstanding),
        .checked_count    (checked_count),
        .restart_count    (restart_count),
        .toggle_count     (toggle_count)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure: stall about 15% of cycles, never while quiet.
    always @(negedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Q32.16 position of a whole number of frames
    function automatic logic [POS_W-1:0] frames(int unsigned n);
        return POS_W'(n) << FRAC_W;
    endfunction

    function automatic logic [POS_W-1:0] random_position();
        case ($urandom_range(3))
            0:       return '0;
            1:       return POS_TOP;
            2:       return frames($urandom_range(4096));
            default: return POS_W'({$urandom, $urandom});
        endcase
    endfunction

    // Writes all four region registers on back-to-back cycles. Called at a
    // falling edge with the block idle; returns at a falling edge.
    task automatic program_regions(input logic [POS_W-1:0] s, input logic [POS_W-1:0] e,
                                   input logic [POS_W-1:0] ls, input logic [POS_W-1:0] le);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_START_POSITION;
        cfg_wdata <= s;
        @(negedge aclk);
        cfg_index <= REG_END_POSITION;
        cfg_wdata <= e;
        @(negedge aclk);
        cfg_index <= REG_LOOP_START;
        cfg_wdata <= ls;
        @(negedge aclk);
        cfg_index <= REG_LOOP_END;
        cfg_wdata <= le;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        config_count++;
    endtask

    // Region settings per random phase: the first few are fixed corner
    // cases, the rest are drawn at random (mostly well-formed regions).
    task automatic program_phase_regions(input int unsigned phase);
        logic [POS_W-1:0] s;
        logic [POS_W-1:0] e;
        logic [POS_W-1:0] ls;
        logic [POS_W-1:0] le;
        case (phase)
            // whole position space for both regions
            0: program_regions('0, POS_TOP, '0, POS_TOP);
            // end below start, empty loop: wraps collapse, clamps pick the end
            1: program_regions(frames(500), frames(10), frames(30), frames(30));
            // tiny regions: nearly every step wraps
            2: program_regions('0, frames(3), frames(1), frames(2));
            // regions pressed against the top of the range
            3: program_regions(POS_TOP - frames(1000), POS_TOP,
                               POS_TOP - frames(600), POS_TOP - frames(100));
            default: begin
                if ($urandom_range(3) == 0) begin
                    s  = random_position();
                    e  = random_position();
                    ls = random_position();
                    le = random_position();
                end else begin
                    s  = frames($urandom_range(2000)) | POS_W'($urandom_range(16'hFFFF));
                    e  = s + frames($urandom_range(1, 800)) + POS_W'($urandom_range(16'hFFFF));
                    ls = s + frames($urandom_range(400));
                    le = ls + frames($urandom_range(400));
                end
                program_regions(s, e, ls, le);
            end
        endcase
    endtask

    // One input transaction. Starts and ends at a falling edge; valid is
    // only lowered for an idle cycle, so back-to-back samples keep it high.
    task automatic send_sample(input logic signed [TRIG_W-1:0] st,
                               input logic signed [TRIG_W-1:0] ft,
                               input logic signed [RATE_W-1:0] rate);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_start_trigger  <= st;
        s_finish_trigger <= ft;
        s_rate_step      <= rate;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        sent_count++;
    endtask

    // Mostly trigger waveforms that rest at or below zero with occasional
    // pulses (so restarts and finish toggles are spread out and the loop
    // gets to run), plus about 10% raw noise on every bit.
    task automatic random_sample();
        logic signed [TRIG_W-1:0] st;
        logic signed [TRIG_W-1:0] ft;
        logic signed [RATE_W-1:0] rate;
        if ($urandom_range(99) < 10) begin
            st   = TRIG_W'($urandom);
            ft   = TRIG_W'($urandom);
            rate = RATE_W'($urandom);
        end else begin
            if ($urandom_range(99) < 8)
                st = TRIG_W'($urandom_range(1, 32767));
            else if ($urandom_range(1) == 1)
                st = '0;
            else
                st = TRIG_W'(-int'($urandom_range(32768)));

            if ($urandom_range(99) < 4)
                ft = TRIG_W'($urandom_range(1, 32767));
            else if ($urandom_range(1) == 1)
                ft = '0;
            else
                ft = TRIG_W'(-int'($urandom_range(32768)));

            case ($urandom_range(9))
                0:       rate = '0;
                7, 8:    rate = RATE_W'($urandom);
                9:       rate = ($urandom_range(1) == 1) ? RATE_MAX : RATE_MIN;
                // a few frames per sample either way
                default: rate = RATE_W'(int'($urandom_range(1 << 19)) - (1 << 18));
            endcase
        end
        send_sample(st, ft, rate);
    endtask

    // Drop valid and wait until every expected result has been taken.
    task automatic drain(input int unsigned extra);
        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    initial begin
        int unsigned phase;

        // every input known from time zero, reset held low
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = REG_START_POSITION;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_start_trigger  = '0;
        s_finish_trigger = '0;
        s_rate_step      = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        program_regions(frames(1), frames(1000), frames(100), frames(1000));
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_sample(DIRECTED_SAMPLES[i][63:48], DIRECTED_SAMPLES[i][47:32],
                        DIRECTED_SAMPLES[i][31:0]);
        drain(SETTLE_CYCLES);

        // random part: new regions per phase, two phases without any idling
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            quiet <= (phase == 5 || phase == 6);
            program_phase_regions(phase);
            repeat (PHASE_ITEMS) random_sample();
            drain(SETTLE_CYCLES);
        end

        // let anything late surface before the verdict
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("sent %0d samples under %0d region settings; %0d positions checked",
                 sent_count, config_count, checked_count);
        $display("saw %0d restart edges and %0d finish toggles; %0d mismatches",
                 restart_count, toggle_count, error_count);
        if (error_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
